@@ design/gic_pkg.sv @@
package gic_pkg;

    // Field widths of the poll and result items.
    localparam int PLAYER_W = 2;
    localparam int BUTTON_W = 16;
    localparam int STICK_W  = 8;
    localparam int MAPPED_W = 6;
    localparam int WORD_W   = 20;
    localparam int TIMER_W  = 4;

    // Configuration register widths and the port's data and index widths.
    localparam int LIMIT_W   = 6;
    localparam int THRESH_W  = 5;
    localparam int DELAY_W   = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_STICK_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_THRESH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_THRESH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY  = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [LIMIT_W-1:0]  STICK_LIMIT_RST   = 6'd45;
    localparam logic [THRESH_W-1:0] PRESS_THRESH_RST  = 5'd27;
    localparam logic [THRESH_W-1:0] RELEASE_THRESH_RST = 5'd8;
    localparam logic [DELAY_W-1:0]  REPEAT_DELAY_RST  = 4'd9;

    // Default number of players with stored state.
    localparam int PLAYERS_DEF = 4;

    // Bit positions of the stick directions in the held word.
    localparam int BIT_RIGHT = 16;
    localparam int BIT_LEFT  = 17;
    localparam int BIT_UP    = 18;
    localparam int BIT_DOWN  = 19;

    // Response curve, indexed by clamped stick magnitude.
    localparam int CURVE_LEN = 56;
    localparam logic [LIMIT_W-1:0] CURVE_MAX_IDX = 6'(CURVE_LEN - 1);
    localparam logic [4:0] CURVE [0:CURVE_LEN-1] = '{
        5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0,
        5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd3,  5'd3,
        5'd3,  5'd4,  5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd10,
        5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18,
        5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25, 5'd26,
        5'd27, 5'd28, 5'd29, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31,
        5'd31, 5'd31, 5'd0,  5'd0,  5'd1,  5'd0,  5'd0,  5'd0
    };

    // Clamp one raw axis to +/- lim and map it through the curve, keeping the sign.
    function automatic logic signed [MAPPED_W-1:0] map_axis(
        input logic signed [STICK_W-1:0] raw,
        input logic [LIMIT_W-1:0]        lim
    );
        logic [STICK_W-1:0]  mag;
        logic [LIMIT_W-1:0]  cmag;
        logic [MAPPED_W-1:0] val;
        mag  = raw[STICK_W-1] ? STICK_W'(-raw) : STICK_W'(raw);
        cmag = (mag > STICK_W'(lim)) ? lim : mag[LIMIT_W-1:0];
        val  = {1'b0, CURVE[cmag]};
        return raw[STICK_W-1] ? -val : val;
    endfunction

endpackage

@@ design/gamepad_input_conditioner_top.sv @@
// Channel   Direction  Handshake              Payload
// poll      in         in_valid / in_stall    player, buttons, stick_x, stick_y
// result    out        out_valid / out_stall  player_out, mapped_x, mapped_y,
//                                             held, pressed, repeat_res
// config    in         cfg_we                 cfg_index, cfg_data
//
// One result per poll, offered on out_valid from the result register.
// Unless the result stalls, a new poll is taken every cycle; the rate is set by
// the single compute stage between the input and result registers, where the
// per-player held word and repeat timer are read and written back in the same cycle.
// Reset clears the pipeline valids and all per-player state; config registers reset.
// A stalled result holds the pipeline; one more poll waits in the input register.
module gamepad_input_conditioner_top #(
    parameter int PLAYERS = gic_pkg::PLAYERS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gic_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gic_pkg::CFG_DAT_W-1:0]        cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [gic_pkg::PLAYER_W-1:0]         player,
    input  logic [gic_pkg::BUTTON_W-1:0]         buttons,
    input  logic signed [gic_pkg::STICK_W-1:0]   stick_x,
    input  logic signed [gic_pkg::STICK_W-1:0]   stick_y,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [gic_pkg::PLAYER_W-1:0]         player_out,
    output logic signed [gic_pkg::MAPPED_W-1:0]  mapped_x,
    output logic signed [gic_pkg::MAPPED_W-1:0]  mapped_y,
    output logic [gic_pkg::WORD_W-1:0]           held,
    output logic [gic_pkg::WORD_W-1:0]           pressed,
    output logic [gic_pkg::WORD_W-1:0]           repeat_res
);
    import gic_pkg::*;

    localparam int IDX_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

    // Configuration registers.
    logic [LIMIT_W-1:0]  stick_limit_reg;
    logic [THRESH_W-1:0] press_thresh_reg;
    logic [THRESH_W-1:0] release_thresh_reg;
    logic [DELAY_W-1:0]  repeat_delay_reg;

    // Input register.
    logic                       in_vld_reg;
    logic [PLAYER_W-1:0]        in_player_reg;
    logic [BUTTON_W-1:0]        in_buttons_reg;
    logic signed [STICK_W-1:0]  in_x_reg;
    logic signed [STICK_W-1:0]  in_y_reg;

    // Per-player state.
    logic [WORD_W-1:0]  held_bits_reg [PLAYERS];
    logic [TIMER_W-1:0] timer_reg [PLAYERS];

    // Result register.
    logic                       out_vld_reg;
    logic [PLAYER_W-1:0]        player_out_reg;
    logic signed [MAPPED_W-1:0] mapped_x_reg;
    logic signed [MAPPED_W-1:0] mapped_y_reg;
    logic [WORD_W-1:0]          held_reg;
    logic [WORD_W-1:0]          pressed_reg;
    logic [WORD_W-1:0]          repeat_reg;

    // Compute stage signals.
    logic                       advance;
    logic                       has_state;
    logic [IDX_W-1:0]           pidx;
    logic [WORD_W-1:0]          prev;
    logic [TIMER_W-1:0]         timer;
    logic [LIMIT_W-1:0]         lim;
    logic signed [MAPPED_W-1:0] mx;
    logic signed [MAPPED_W-1:0] my;
    logic signed [MAPPED_W:0]   pt;
    logic signed [MAPPED_W:0]   rt;
    logic signed [MAPPED_W:0]   mx_w;
    logic signed [MAPPED_W:0]   my_w;
    logic [3:0]                 dir;
    logic [WORD_W-1:0]          held_next;
    logic [WORD_W-1:0]          pressed_next;
    logic [WORD_W-1:0]          repeat_next;
    logic [TIMER_W-1:0]         timer_next;

    // The pipeline moves whenever the result register is free or being taken.
    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = in_vld_reg && !advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_limit_reg    <= STICK_LIMIT_RST;
            press_thresh_reg   <= PRESS_THRESH_RST;
            release_thresh_reg <= RELEASE_THRESH_RST;
            repeat_delay_reg   <= REPEAT_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STICK_LIMIT:    stick_limit_reg    <= cfg_data[LIMIT_W-1:0];
                REG_PRESS_THRESH:   press_thresh_reg   <= cfg_data[THRESH_W-1:0];
                REG_RELEASE_THRESH: release_thresh_reg <= cfg_data[THRESH_W-1:0];
                REG_REPEAT_DELAY:   repeat_delay_reg   <= cfg_data[DELAY_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Input register payload, loaded on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_player_reg  <= player;
            in_buttons_reg <= buttons;
            in_x_reg       <= stick_x;
            in_y_reg       <= stick_y;
        end
    end

    // Read the player's previous state; players without state start from zero.
    always_comb
    begin
        has_state = 32'(in_player_reg) < PLAYERS;
        pidx      = IDX_W'(in_player_reg);
        prev      = has_state ? held_bits_reg[pidx] : '0;
        timer     = has_state ? timer_reg[pidx] : '0;
    end

    // Clamp and curve-map both axes.
    always_comb
    begin
        lim = (stick_limit_reg > CURVE_MAX_IDX) ? CURVE_MAX_IDX : stick_limit_reg;
        mx  = map_axis(in_x_reg, lim);
        my  = map_axis(in_y_reg, lim);
    end

    // Direction hysteresis: set test first, then the clear test wins.
    always_comb
    begin
        pt   = signed'({2'b00, press_thresh_reg});
        rt   = signed'({2'b00, release_thresh_reg});
        mx_w = {mx[MAPPED_W-1], mx};
        my_w = {my[MAPPED_W-1], my};
        dir  = prev[BIT_DOWN:BIT_RIGHT];
        if (mx_w >= pt)  dir[BIT_RIGHT-BIT_RIGHT] = 1'b1;
        if (mx_w <= -pt) dir[BIT_LEFT-BIT_RIGHT]  = 1'b1;
        if (my_w >= pt)  dir[BIT_UP-BIT_RIGHT]    = 1'b1;
        if (my_w <= -pt) dir[BIT_DOWN-BIT_RIGHT]  = 1'b1;
        if (mx_w < rt)   dir[BIT_RIGHT-BIT_RIGHT] = 1'b0;
        if (mx_w > -rt)  dir[BIT_LEFT-BIT_RIGHT]  = 1'b0;
        if (my_w < rt)   dir[BIT_UP-BIT_RIGHT]    = 1'b0;
        if (my_w > -rt)  dir[BIT_DOWN-BIT_RIGHT]  = 1'b0;
    end

    // Held, pressed and auto-repeat words with the repeat timer.
    always_comb
    begin
        held_next    = {dir, in_buttons_reg};
        pressed_next = ~prev & held_next;
        timer_next   = timer;
        priority if (held_next == '0)
        begin
            timer_next  = '0;
            repeat_next = '0;
        end
        else if (timer >= repeat_delay_reg)
        begin
            repeat_next = held_next;
        end
        else
        begin
            timer_next  = timer + TIMER_W'(1);
            repeat_next = pressed_next;
        end
    end

    // Per-player state write-back as the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYERS; i++)
            begin
                held_bits_reg[i] <= '0;
                timer_reg[i]     <= '0;
            end
        end
        else if (in_vld_reg && advance && has_state)
        begin
            held_bits_reg[pidx] <= held_next;
            timer_reg[pidx]     <= timer_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (in_vld_reg && advance)
        begin
            player_out_reg <= in_player_reg;
            mapped_x_reg   <= mx;
            mapped_y_reg   <= my;
            held_reg       <= held_next;
            pressed_reg    <= pressed_next;
            repeat_reg     <= repeat_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign player_out = player_out_reg;
    assign mapped_x   = mapped_x_reg;
    assign mapped_y   = mapped_y_reg;
    assign held       = held_reg;
    assign pressed    = pressed_reg;
    assign repeat_res = repeat_reg;

endmodule

@@ design/gic_checker.sv @@
module gic_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [gic_pkg::PLAYER_W-1:0]        player_out,
    input logic signed [gic_pkg::MAPPED_W-1:0] mapped_x,
    input logic signed [gic_pkg::MAPPED_W-1:0] mapped_y,
    input logic [gic_pkg::WORD_W-1:0]          held,
    input logic [gic_pkg::WORD_W-1:0]          pressed,
    input logic [gic_pkg::WORD_W-1:0]          repeat_res
);
    import gic_pkg::*;

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result does not change.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(held) && $stable(pressed) &&
            $stable(repeat_res) && $stable(player_out) &&
            $stable(mapped_x) && $stable(mapped_y))
        else $error("result payload changed while stalled");

    // Newly pressed and repeat bits are always a subset of the held word.
    a_subset_of_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((pressed & ~held) == '0) && ((repeat_res & ~held) == '0))
        else $error("pressed or repeat bit outside held word");

    // The curve never reaches the most negative code.
    a_mapped_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mapped_x != -MAPPED_W'(32)) && (mapped_y != -MAPPED_W'(32)))
        else $error("mapped stick value out of range");

endmodule

bind gamepad_input_conditioner_top gic_checker u_gic_checker (.*);
